[hw/rtl/smoothlife_cell_transition_unit_defines.svh]
// assertion macros for the checker file
`ifndef SMOOTHLIFE_CELL_TRANSITION_UNIT_DEFINES_SVH
`define SMOOTHLIFE_CELL_TRANSITION_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

[hw/rtl/slt_pkg.sv]
// types, constants and arithmetic helpers of the smoothlife cell transition unit
`default_nettype none

package slt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = FRAC_BITS + 1;
	localparam int WID_W     = FRAC_BITS;
	localparam int REC_W     = FRAC_BITS + 8;
	localparam int W_W       = FRAC_BITS + 2;
	localparam int SD_W      = VAL_W + 3;
	localparam int P_W       = VAL_W + REC_W + 1;
	localparam int SQ_W      = 2 * VAL_W;
	localparam int HP_W      = VAL_W + W_W;
	localparam int BL_W      = 2 * VAL_W + 1;
	localparam int STAGES    = 10;
	localparam int CFG_IDX_W = 3;

	typedef logic [VAL_W-1:0]     val_t;
	typedef logic [WID_W-1:0]     wid_t;
	typedef logic [REC_W-1:0]     rec_t;
	typedef logic [W_W-1:0]       w_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	typedef struct packed {
		logic below;
		logic above;
	} region_t;

	typedef struct packed {
		region_t rg;
		val_t    d;
	} front_t;

	localparam val_t ONE       = val_t'(1) << FRAC_BITS;
	localparam val_t HALF      = val_t'(1) << (FRAC_BITS - 1);
	localparam w_t   THREE_ONE = w_t'(3) << FRAC_BITS;

	localparam cfg_idx_t REG_BIRTH_LOW   = cfg_idx_t'(0);
	localparam cfg_idx_t REG_BIRTH_HIGH  = cfg_idx_t'(1);
	localparam cfg_idx_t REG_DEATH_LOW   = cfg_idx_t'(2);
	localparam cfg_idx_t REG_DEATH_HIGH  = cfg_idx_t'(3);
	localparam cfg_idx_t REG_OUTER_WIDTH = cfg_idx_t'(4);
	localparam cfg_idx_t REG_INNER_WIDTH = cfg_idx_t'(5);
	localparam cfg_idx_t REG_OUTER_RECIP = cfg_idx_t'(6);
	localparam cfg_idx_t REG_INNER_RECIP = cfg_idx_t'(7);

	localparam val_t BIRTH_LOW_RST   = val_t'(18219);
	localparam val_t BIRTH_HIGH_RST  = val_t'(23921);
	localparam val_t DEATH_LOW_RST   = val_t'(17498);
	localparam val_t DEATH_HIGH_RST  = val_t'(29164);
	localparam wid_t OUTER_WIDTH_RST = wid_t'(1835);
	localparam wid_t INNER_WIDTH_RST = wid_t'(9634);
	localparam rec_t OUTER_RECIP_RST = rec_t'(2340571);
	localparam rec_t INNER_RECIP_RST = rec_t'(445823);

	// region test and offset d = 2x - 2a + e
	function automatic front_t herm_front(val_t x, val_t a, wid_t e);
		logic signed [SD_W-1:0] sd;
		logic signed [SD_W-1:0] lim;
		front_t f;
		sd = $signed({2'b00, x, 1'b0}) - $signed({2'b00, a, 1'b0})
			+ $signed({{(SD_W-WID_W){1'b0}}, e});
		lim = $signed({{(SD_W-WID_W-1){1'b0}}, e, 1'b0});
		f.rg.below = sd[SD_W-1];
		f.rg.above = sd > lim;
		f.d = sd[VAL_W-1:0];
		return f;
	endfunction

	// t = (d * recip + one) >> (frac + 1), saturated
	function automatic val_t herm_t(val_t d, rec_t r);
		logic [P_W-1:0] s;
		logic [P_W-FRAC_BITS-2:0] q;
		s = P_W'(d) * P_W'(r) + P_W'(ONE);
		q = s[P_W-1:FRAC_BITS+1];
		if (q > (P_W-FRAC_BITS-1)'(ONE))
			return ONE;
		return q[VAL_W-1:0];
	endfunction

	function automatic val_t herm_sq(val_t t);
		logic [SQ_W-1:0] s;
		s = SQ_W'(t) * SQ_W'(t) + SQ_W'(HALF);
		return s[FRAC_BITS+VAL_W-1:FRAC_BITS];
	endfunction

	function automatic w_t herm_w(val_t t);
		return THREE_ONE - {t, 1'b0};
	endfunction

	function automatic val_t herm_out(val_t t2, w_t w, region_t rg);
		logic [HP_W-1:0] s;
		logic [HP_W-FRAC_BITS-1:0] q;
		s = HP_W'(t2) * HP_W'(w) + HP_W'(HALF);
		q = s[HP_W-1:FRAC_BITS];
		if (rg.below)
			return '0;
		if (rg.above)
			return ONE;
		if (q > (HP_W-FRAC_BITS)'(ONE))
			return ONE;
		return q[VAL_W-1:0];
	endfunction

	function automatic val_t blend(val_t p, val_t q, val_t h);
		logic [BL_W-1:0] s;
		s = BL_W'(p) * BL_W'(val_t'(ONE - h)) + BL_W'(q) * BL_W'(h) + BL_W'(HALF);
		return s[FRAC_BITS+VAL_W-1:FRAC_BITS];
	endfunction

	function automatic val_t interval_out(val_t h1, val_t h2);
		logic [SQ_W-1:0] s;
		logic [SQ_W-FRAC_BITS-1:0] q;
		s = SQ_W'(h1) * SQ_W'(val_t'(ONE - h2)) + SQ_W'(HALF);
		q = s[SQ_W-1:FRAC_BITS];
		if (q > (SQ_W-FRAC_BITS)'(ONE))
			return ONE;
		return q[VAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/smoothlife_cell_transition_unit.sv]
// smoothlife cell transition unit, ten-stage pipeline
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    outer_filling, inner_filling
//  out      source     out_valid / out_stall  new_value
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one cell per cycle sustained while out_stall is low; each cell passes through every stage to new_value
// four stages per hermite step (region test, t, square, cubic), one blend, one interval
// arst_n clears valid bits and loads the default limits, widths and reciprocals
// out_stall holds the last stage; earlier stages keep moving into empty slots
// cfg_ready is always high; each write is registered on the clock edge that accepts it
`default_nettype none

module smoothlife_cell_transition_unit import slt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  val_t     outer_filling,
	input  val_t     inner_filling,
	output logic     out_valid,
	input  logic     out_stall,
	output val_t     new_value,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  cfg_idx_t cfg_index,
	input  rec_t     cfg_data
);

	val_t birth_low_q, birth_high_q, death_low_q, death_high_q;
	wid_t outer_width_q, inner_width_q;
	rec_t outer_recip_q, inner_recip_q;

	logic [STAGES:1]   vld_q;
	logic [STAGES+1:1] en;

	front_t  fi_s1;
	val_t    outer_s1, outer_s2, outer_s3, outer_s4, outer_s5;
	val_t    ti_s2, t2i_s3, hm_s4;
	region_t ri_s2, ri_s3;
	w_t      wi_s3;
	val_t    lo_s5, hi_s5;
	front_t  flo_s6, fhi_s6;
	val_t    tlo_s7, thi_s7, t2lo_s8, t2hi_s8;
	region_t rlo_s7, rhi_s7, rlo_s8, rhi_s8;
	w_t      wlo_s8, whi_s8;
	val_t    h1_s9, h2_s9, r_s10;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_low_q   <= BIRTH_LOW_RST;
			birth_high_q  <= BIRTH_HIGH_RST;
			death_low_q   <= DEATH_LOW_RST;
			death_high_q  <= DEATH_HIGH_RST;
			outer_width_q <= OUTER_WIDTH_RST;
			inner_width_q <= INNER_WIDTH_RST;
			outer_recip_q <= OUTER_RECIP_RST;
			inner_recip_q <= INNER_RECIP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BIRTH_LOW:   birth_low_q   <= cfg_data[VAL_W-1:0];
				REG_BIRTH_HIGH:  birth_high_q  <= cfg_data[VAL_W-1:0];
				REG_DEATH_LOW:   death_low_q   <= cfg_data[VAL_W-1:0];
				REG_DEATH_HIGH:  death_high_q  <= cfg_data[VAL_W-1:0];
				REG_OUTER_WIDTH: outer_width_q <= cfg_data[WID_W-1:0];
				REG_INNER_WIDTH: inner_width_q <= cfg_data[WID_W-1:0];
				REG_OUTER_RECIP: outer_recip_q <= cfg_data;
				REG_INNER_RECIP: inner_recip_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage moves when it is empty or the next one moves
	always_comb begin
		en[STAGES+1] = !out_stall;
		for (int i = STAGES; i >= 1; i--)
			en[i] = !vld_q[i] || en[i+1];
	end

	assign in_stall  = !en[1];
	assign out_valid = vld_q[STAGES];
	assign new_value = r_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= in_valid;
			for (int i = 2; i <= STAGES; i++)
				if (en[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	// inner hermite step
	always_ff @(posedge clk) begin
		if (en[1]) begin
			fi_s1    <= herm_front(inner_filling, HALF, inner_width_q);
			outer_s1 <= outer_filling;
		end
		if (en[2]) begin
			ti_s2    <= herm_t(fi_s1.d, inner_recip_q);
			ri_s2    <= fi_s1.rg;
			outer_s2 <= outer_s1;
		end
		if (en[3]) begin
			t2i_s3   <= herm_sq(ti_s2);
			wi_s3    <= herm_w(ti_s2);
			ri_s3    <= ri_s2;
			outer_s3 <= outer_s2;
		end
		if (en[4]) begin
			hm_s4    <= herm_out(t2i_s3, wi_s3, ri_s3);
			outer_s4 <= outer_s3;
		end
	end

	// limit mix
	always_ff @(posedge clk) begin
		if (en[5]) begin
			lo_s5    <= blend(birth_low_q, death_low_q, hm_s4);
			hi_s5    <= blend(birth_high_q, death_high_q, hm_s4);
			outer_s5 <= outer_s4;
		end
	end

	// outer hermite edges and interval
	always_ff @(posedge clk) begin
		if (en[6]) begin
			flo_s6 <= herm_front(outer_s5, lo_s5, outer_width_q);
			fhi_s6 <= herm_front(outer_s5, hi_s5, outer_width_q);
		end
		if (en[7]) begin
			tlo_s7 <= herm_t(flo_s6.d, outer_recip_q);
			thi_s7 <= herm_t(fhi_s6.d, outer_recip_q);
			rlo_s7 <= flo_s6.rg;
			rhi_s7 <= fhi_s6.rg;
		end
		if (en[8]) begin
			t2lo_s8 <= herm_sq(tlo_s7);
			t2hi_s8 <= herm_sq(thi_s7);
			wlo_s8  <= herm_w(tlo_s7);
			whi_s8  <= herm_w(thi_s7);
			rlo_s8  <= rlo_s7;
			rhi_s8  <= rhi_s7;
		end
		if (en[9]) begin
			h1_s9 <= herm_out(t2lo_s8, wlo_s8, rlo_s8);
			h2_s9 <= herm_out(t2hi_s8, whi_s8, rhi_s8);
		end
		if (en[10])
			r_s10 <= interval_out(h1_s9, h2_s9);
	end

endmodule

`default_nettype wire

[hw/rtl/slt_checker.sv]
// port-level checker for the smoothlife cell transition unit, with its bind
`default_nettype none
`include "smoothlife_cell_transition_unit_defines.svh"

module slt_checker import slt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input val_t new_value
);

	`SLT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(new_value), "stalled result changed")
	`SLT_ASSERT(a_out_range, out_valid |-> new_value <= ONE, "result above one")
	`SLT_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled while output free")

endmodule

bind smoothlife_cell_transition_unit slt_checker u_slt_checker (.*);

`default_nettype wire
